// ===== rtl/sactl_pkg.sv =====
// sactl_pkg: shared constants, state codes and helper functions for the
// set-associative tag store. No dependencies.
package sactl_pkg;

    localparam int SACTL_SETS       = 256;
    localparam int SACTL_WAYS       = 16;
    localparam int SACTL_ADDR_BITS  = 48;
    localparam int SACTL_STAMP_BITS = 32;

    // item field widths on the ports
    localparam int LINE_W   = 48;
    localparam int TS_W     = 32;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IX_W = 2;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 216;

    // widest masked set index value (set_index_bits is four bits)
    localparam int SIDX_W = 15;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_SIDX  = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_WAYS  = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_SEED  = 2'd3;

    // statistics counter slots
    localparam int CNT_RD_ACC   = 0;
    localparam int CNT_WR_ACC   = 1;
    localparam int CNT_RD_MISS  = 2;
    localparam int CNT_WR_MISS  = 3;
    localparam int CNT_DIRTY_EV = 4;
    localparam int CNT_NUM      = 5;

    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_INSTALL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVQ,
        S_DIVR,
        S_LOOK,
        S_LRU,
        S_RAND,
        S_DONE
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        lfsr_step = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

endpackage

// ===== rtl/sactl_ram.sv =====
// sactl_ram: generic single-clock RAM, one write port and one read port,
// registered read data. Depends on nothing.
module sactl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/set_assoc_cache_tag_lru_top.sv =====
// Tag store of a set-associative cache with LRU or pseudo-random replacement
// and access statistics. Each item takes one read of its set row from the tag
// RAM and one write-back. An LRU eviction walks the stamps one way a cycle;
// a random eviction reduces the LFSR value one bit a cycle. With a set count
// that is not a power of two the set index goes through a reciprocal division
// in states S_DIVQ and S_DIVR first. A row flag per set stands for the cleared
// RAM after reset, so there is no clearing pass. The block holds one item at
// a time; the next is taken once the result sits in the output register.
// Depends on sactl_pkg and sactl_ram.
module set_assoc_cache_tag_lru_top
    import sactl_pkg::*;
#(
    parameter int SETS       = SACTL_SETS,
    parameter int WAYS       = SACTL_WAYS,
    parameter int ADDR_BITS  = SACTL_ADDR_BITS,
    parameter int STAMP_BITS = SACTL_STAMP_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_IX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // line_addr[47:0], write_dirty[48], timestamp[80:49], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // op[0]
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit[0], victim_valid[1], victim_dirty[2], victim_addr[50:3],
    // read_accesses[82:51], write_accesses[114:83], read_misses[146:115],
    // write_misses[178:147], dirty_evictions[210:179], zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W    = $clog2(WAYS + 1);
    localparam int E_W       = ADDR_BITS + STAMP_BITS + 2;
    localparam int ROW_W     = WAYS * E_W;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SETS);

    state_t state_reg, state_next;

    logic                  mode_reg;
    logic [3:0]            sidx_bits_reg;
    logic [4:0]            ways_cfg_reg;
    logic [15:0]           lfsr_reg;

    logic                  op_reg;
    logic                  md_reg;
    logic [LINE_W-1:0]     addr_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [SIDX_W-1:0]     sv_reg;
    logic [SIDX_W-1:0]     q_reg;
    logic [SET_W-1:0]      set_reg;
    logic                  row_ok_rd_reg;
    logic [SETS-1:0]       row_ok_reg;
    logic [WAY_W-1:0]      slot_reg;
    logic                  hit_reg;
    logic                  evict_reg;
    logic [STAMP_BITS-1:0] oldest_reg;
    logic [WCNT_W-1:0]     wcnt_reg;
    logic [3:0]            bcnt_reg;
    logic [WCNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]      cnt_reg [CNT_NUM];
    logic [CNT_W-1:0]      cnt_next [CNT_NUM];
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    logic                  accept;
    logic                  out_free;
    logic [WCNT_W-1:0]     ways_act;
    logic [SIDX_W-1:0]     sv_now;
    logic [SET_W-1:0]      set_pow2;
    logic [16:0]           r_wide;
    logic [16:0]           r_fix;
    logic                  ram_re;
    logic                  ram_we;
    logic [SET_W-1:0]      ram_raddr;
    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      row_new;
    logic [ADDR_BITS+LINE_W-1:0] tag_ext;
    logic [ADDR_BITS-1:0]  tag_in;
    logic [STAMP_BITS+TS_W-1:0]  stamp_ext;

    logic                  e_valid [WAYS];
    logic [ADDR_BITS-1:0]  e_tag   [WAYS];
    logic [STAMP_BITS-1:0] e_stamp [WAYS];

    logic                  hit_found, inv_found;
    logic [WAY_W-1:0]      hit_way, inv_way;
    logic [E_W-1:0]        sel_e, new_e;
    logic                  sel_dirty;
    logic [ADDR_BITS-1:0]  sel_tag;
    logic [ADDR_BITS+LINE_W-1:0] vext;
    logic [LINE_W-1:0]     vaddr;
    logic                  vdirty;
    logic [WCNT_W:0]       rem_t;
    logic [WCNT_W:0]       rem_new;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        if (ways_cfg_reg == 5'd0) begin
            ways_act = WCNT_W'(1);
        end else if (int'(ways_cfg_reg) > WAYS) begin
            ways_act = WCNT_W'(WAYS);
        end else begin
            ways_act = WCNT_W'(ways_cfg_reg);
        end
    end

    // masked set index value; a shift by fifteen wraps to an all-ones mask
    assign sv_now   = s_tdata[SIDX_W-1:0] & ((SIDX_W'(1) << sidx_bits_reg) - SIDX_W'(1));
    assign set_pow2 = (SETS == 1) ? '0 : SET_W'(sv_now);

    // remainder after reciprocal estimate, off by at most one set count
    assign r_wide = 17'(sv_reg) - 17'(q_reg * SETS);
    assign r_fix  = (r_wide >= 17'(SETS)) ? r_wide - 17'(SETS) : r_wide;

    assign tag_ext   = {{ADDR_BITS{1'b0}}, addr_reg};
    assign tag_in    = tag_ext[ADDR_BITS-1:0];
    assign stamp_ext = {{STAMP_BITS{1'b0}}, s_tdata[80:49]};

    assign ram_re    = (accept && SETS_POW2) || (state_reg == S_DIVR);
    assign ram_raddr = (state_reg == S_DIVR) ? SET_W'(r_fix) : set_pow2;
    assign ram_we    = (state_reg == S_DONE) && out_free;

    sactl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a row never written reads as all clear
    assign row = row_ok_rd_reg ? ram_rdata : '0;

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        assign e_valid[g] = row[g*E_W];
        assign e_tag[g]   = row[g*E_W+2 +: ADDR_BITS];
        assign e_stamp[g] = row[g*E_W+2+ADDR_BITS +: STAMP_BITS];
    end

    // lowest matching way and lowest free way among the ways in use
    always_comb begin
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w < int'(ways_act)) begin
                if (e_valid[w] && (e_tag[w] == tag_in)) begin
                    hit_found = 1'b1;
                    hit_way   = WAY_W'(w);
                end
                if (!e_valid[w]) begin
                    inv_found = 1'b1;
                    inv_way   = WAY_W'(w);
                end
            end
        end
    end

    assign rem_t   = {rem_reg, lfsr_reg[bcnt_reg]};
    assign rem_new = (rem_t >= (WCNT_W+1)'(ways_act)) ? rem_t - (WCNT_W+1)'(ways_act) : rem_t;

    assign sel_e     = row[slot_reg*E_W +: E_W];
    assign sel_dirty = sel_e[1];
    assign sel_tag   = sel_e[2 +: ADDR_BITS];

    always_comb begin
        if (op_reg == OP_INSTALL) begin
            new_e = {stamp_reg, tag_in, md_reg, 1'b1};
        end else if (hit_reg) begin
            new_e = {stamp_reg, sel_tag, sel_dirty | md_reg, 1'b1};
        end else begin
            new_e = sel_e;
        end
        row_new = row;
        row_new[slot_reg*E_W +: E_W] = new_e;
    end

    assign vext   = {{LINE_W{1'b0}}, sel_tag};
    assign vdirty = evict_reg && sel_dirty;
    assign vaddr  = evict_reg ? vext[LINE_W-1:0] : '0;

    always_comb begin
        for (int i = 0; i < CNT_NUM; i++) begin
            cnt_next[i] = cnt_reg[i];
        end
        if (op_reg == OP_LOOKUP) begin
            if (md_reg) begin
                cnt_next[CNT_WR_ACC] = sat_inc(cnt_reg[CNT_WR_ACC]);
                if (!hit_reg) begin
                    cnt_next[CNT_WR_MISS] = sat_inc(cnt_reg[CNT_WR_MISS]);
                end
            end else begin
                cnt_next[CNT_RD_ACC] = sat_inc(cnt_reg[CNT_RD_ACC]);
                if (!hit_reg) begin
                    cnt_next[CNT_RD_MISS] = sat_inc(cnt_reg[CNT_RD_MISS]);
                end
            end
        end else if (vdirty) begin
            cnt_next[CNT_DIRTY_EV] = sat_inc(cnt_reg[CNT_DIRTY_EV]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = SETS_POW2 ? S_LOOK : S_DIVQ;
                end
            end
            S_DIVQ: state_next = S_DIVR;
            S_DIVR: state_next = S_LOOK;
            S_LOOK: begin
                if (op_reg == OP_LOOKUP || inv_found) begin
                    state_next = S_DONE;
                end else if (mode_reg) begin
                    state_next = S_RAND;
                end else if (ways_act == WCNT_W'(1)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_LRU;
                end
            end
            S_LRU: begin
                if (wcnt_reg == ways_act - WCNT_W'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_RAND: begin
                if (bcnt_reg == 4'd0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration, lfsr, row flags, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            sidx_bits_reg <= 4'd6;
            ways_cfg_reg  <= 5'd8;
            lfsr_reg      <= LFSR_ONE;
            row_ok_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < CNT_NUM; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_MODE: mode_reg      <= cfg_wdata[0];
                    CFG_SIDX: sidx_bits_reg <= cfg_wdata[3:0];
                    CFG_WAYS: ways_cfg_reg  <= cfg_wdata[4:0];
                    CFG_SEED: lfsr_reg      <= (cfg_wdata == '0) ? LFSR_ONE : cfg_wdata;
                    default: ;
                endcase
            end else if (state_reg == S_LOOK && op_reg == OP_INSTALL && !inv_found
                         && mode_reg) begin
                lfsr_reg <= lfsr_step(lfsr_reg);
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (ram_we) begin
                row_ok_reg[set_reg] <= 1'b1;
                m_tvalid_reg        <= 1'b1;
                for (int i = 0; i < CNT_NUM; i++) begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_tuser;
            addr_reg  <= s_tdata[LINE_W-1:0];
            md_reg    <= s_tdata[48];
            stamp_reg <= stamp_ext[STAMP_BITS-1:0];
            sv_reg    <= sv_now;
            set_reg   <= set_pow2;
        end
        if (ram_re) begin
            row_ok_rd_reg <= row_ok_reg[ram_raddr];
        end
        unique case (state_reg)
            S_DIVQ: q_reg <= SIDX_W'((48'(sv_reg) * 48'(RECIP)) >> 32);
            S_DIVR: set_reg <= SET_W'(r_fix);
            S_LOOK: begin
                evict_reg <= 1'b0;
                hit_reg   <= 1'b0;
                if (op_reg == OP_LOOKUP) begin
                    hit_reg  <= hit_found;
                    slot_reg <= hit_way;
                end else if (inv_found) begin
                    slot_reg <= inv_way;
                end else begin
                    evict_reg  <= 1'b1;
                    slot_reg   <= '0;
                    oldest_reg <= e_stamp[0];
                    wcnt_reg   <= WCNT_W'(1);
                    bcnt_reg   <= 4'd15;
                    rem_reg    <= '0;
                end
            end
            S_LRU: begin
                if (e_stamp[wcnt_reg[WAY_W-1:0]] < oldest_reg) begin
                    oldest_reg <= e_stamp[wcnt_reg[WAY_W-1:0]];
                    slot_reg   <= wcnt_reg[WAY_W-1:0];
                end
                wcnt_reg <= wcnt_reg + WCNT_W'(1);
            end
            S_RAND: begin
                rem_reg  <= rem_new[WCNT_W-1:0];
                slot_reg <= rem_new[WAY_W-1:0];
                bcnt_reg <= bcnt_reg - 4'd1;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {5'd0,
                                    cnt_next[CNT_DIRTY_EV], cnt_next[CNT_WR_MISS],
                                    cnt_next[CNT_RD_MISS], cnt_next[CNT_WR_ACC],
                                    cnt_next[CNT_RD_ACC], vaddr, vdirty, evict_reg,
                                    (op_reg == OP_LOOKUP) && hit_reg};
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_we_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_DONE) && out_free)
        else $error("row written outside write-back");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result appeared without write-back");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != 16'd0)
        else $error("replacement lfsr stuck at zero");

    a_evict_install: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && evict_reg) |-> (op_reg == OP_INSTALL))
        else $error("eviction on a lookup item");

    a_hit_no_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[1])
        else $error("hit and victim in one item");
`endif

endmodule

// ===== dv/set_assoc_cache_tag_lru_chk.sv =====
// set_assoc_cache_tag_lru_chk: watches both item channels, predicts each result
// of the cache tag store and compares it whole. Depends on sactl_pkg.
module set_assoc_cache_tag_lru_chk
    import sactl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_IX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CNT_W-1:0]  dirty_ev;
        logic [CNT_W-1:0]  wr_miss;
        logic [CNT_W-1:0]  rd_miss;
        logic [CNT_W-1:0]  wr_acc;
        logic [CNT_W-1:0]  rd_acc;
        logic [LINE_W-1:0] vaddr;
        logic              vdirty;
        logic              vvalid;
        logic              hit;
    } cache_result_t;

    localparam int NE = SACTL_SETS * SACTL_WAYS;

    logic [LINE_W-1:0] tags [NE];
    logic              valids [NE];
    logic              dirties [NE];
    logic [TS_W-1:0]   stamps [NE];
    logic [CNT_W-1:0]  counts [CNT_NUM];
    logic [15:0]       lfsr;
    logic              rmode;
    logic [3:0]        sidx_bits;
    logic [4:0]        ways_cfg;

    cache_result_t expected_results[$];

    function automatic void bump(int k);
        counts[k] = sat_inc(counts[k]);
    endfunction

    // one item through the tag store, result pushed on the queue
    function automatic void predict_access(logic op, logic [LINE_W-1:0] addr,
                                           logic dirty, logic [TS_W-1:0] ts);
        cache_result_t r;
        int ways, set, base, slot, e;
        logic [TS_W-1:0] oldest;
        r = '0;
        ways = (ways_cfg == 0) ? 1 : (ways_cfg > SACTL_WAYS ? SACTL_WAYS : ways_cfg);
        set = int'((addr & ((48'd1 << sidx_bits) - 1)) % SACTL_SETS);
        base = set * SACTL_WAYS;
        if (op == OP_LOOKUP) begin
            bump(dirty ? CNT_WR_ACC : CNT_RD_ACC);
            for (int w = 0; w < ways; w++) begin
                e = base + w;
                if (valids[e] && tags[e] == addr) begin
                    r.hit = 1'b1;
                    stamps[e] = ts;
                    if (dirty) dirties[e] = 1'b1;
                    break;
                end
            end
            if (!r.hit) bump(dirty ? CNT_WR_MISS : CNT_RD_MISS);
        end else begin
            slot = ways;
            for (int w = 0; w < ways; w++) begin
                if (!valids[base + w]) begin
                    slot = w;
                    break;
                end
            end
            if (slot == ways) begin
                if (rmode) begin
                    lfsr = (lfsr >> 1) ^ (lfsr[0] ? 16'hB400 : 16'h0);
                    slot = int'(lfsr) % ways;
                end else begin
                    oldest = stamps[base];
                    slot = 0;
                    for (int w = 1; w < ways; w++) begin
                        if (stamps[base + w] < oldest) begin
                            oldest = stamps[base + w];
                            slot = w;
                        end
                    end
                end
                e = base + slot;
                r.vvalid = 1'b1;
                r.vdirty = dirties[e];
                r.vaddr = tags[e];
                if (r.vdirty) bump(CNT_DIRTY_EV);
            end
            e = base + slot;
            tags[e] = addr;
            valids[e] = 1'b1;
            dirties[e] = dirty;
            stamps[e] = ts;
        end
        r.rd_acc = counts[CNT_RD_ACC];
        r.wr_acc = counts[CNT_WR_ACC];
        r.rd_miss = counts[CNT_RD_MISS];
        r.wr_miss = counts[CNT_WR_MISS];
        r.dirty_ev = counts[CNT_DIRTY_EV];
        expected_results.push_back(r);
    endfunction

    always @(posedge aclk) begin
        cache_result_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < NE; i++) begin
                valids[i] = 1'b0;
                dirties[i] = 1'b0;
                stamps[i] = '0;
                tags[i] = '0;
            end
            for (int k = 0; k < CNT_NUM; k++) counts[k] = '0;
            lfsr = LFSR_ONE;
            rmode = 1'b0;
            sidx_bits = 4'd6;
            ways_cfg = 5'd8;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MODE: rmode = cfg_wdata[0];
                    CFG_SIDX: sidx_bits = cfg_wdata[3:0];
                    CFG_WAYS: ways_cfg = cfg_wdata[4:0];
                    CFG_SEED: lfsr = (cfg_wdata == 0) ? LFSR_ONE : cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = cache_result_t'(m_tdata[210:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $realtime, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                        $display("  hit %b/%b vv %b/%b vd %b/%b va %h/%h", want.hit, got.hit,
                                 want.vvalid, got.vvalid, want.vdirty, got.vdirty,
                                 want.vaddr, got.vaddr);
                        $display("  cnt %h/%h %h/%h %h/%h %h/%h %h/%h", want.rd_acc, got.rd_acc,
                                 want.wr_acc, got.wr_acc, want.rd_miss, got.rd_miss,
                                 want.wr_miss, got.wr_miss, want.dirty_ev, got.dirty_ev);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_access(s_tuser, s_tdata[47:0], s_tdata[48], s_tdata[80:49]);
        end
        pending = expected_results.size();
    end
endmodule

// ===== dv/set_assoc_cache_tag_lru_top_tb.sv =====
// set_assoc_cache_tag_lru_top_tb: drives lookups, installs and register writes
// into the cache tag store and gives the verdict. Depends on sactl_pkg, the RTL
// and set_assoc_cache_tag_lru_chk.
module set_assoc_cache_tag_lru_top_tb
    import sactl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IX_W-1:0] cfg_addr = CFG_MODE;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = OP_LOOKUP;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    int fail_count, pending;
    bit no_idle = 1'b0;
    bit long_hold = 1'b0;

    // recent lines, so lookups and re-installs hit resident entries
    logic [LINE_W-1:0] recent_lines[$];
    logic [TS_W-1:0] clock_stamp = '0;

    always #2 aclk = ~aclk;

    set_assoc_cache_tag_lru_top u_top (.*);

    set_assoc_cache_tag_lru_chk u_chk (.*);

    task automatic send_item(logic op, logic [LINE_W-1:0] addr, logic dirty,
                             logic [TS_W-1:0] ts);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, ts, dirty, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        // the block is busy with the item for this cycle anyway
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= ix;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_item(int set_span);
        logic [LINE_W-1:0] a;
        logic op;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5 && recent_lines.size() > 0)
            a = recent_lines[$urandom_range(0, recent_lines.size() - 1)];
        else if (pick < 8)
            a = LINE_W'({$urandom, $urandom}) ^ LINE_W'($urandom_range(0, set_span));
        else
            a = {16'($urandom), $urandom};
        op = $urandom_range(0, 2) == 0;
        if (op) begin
            recent_lines.push_back(a);
            if (recent_lines.size() > 64) void'(recent_lines.pop_front());
        end
        clock_stamp += $urandom_range(0, 3);
        // occasional wild stamps cover every stamp bit
        send_item(op, a, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 15) == 0 ? $urandom : clock_stamp);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                long_hold = 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: fill one set past capacity under LRU, extremes of fields
        write_reg(CFG_WAYS, 16'd2);
        for (int i = 0; i < 4; i++)
            send_item(OP_INSTALL, 48'h40 * i, i[0], 32'(10 - i));
        send_item(OP_LOOKUP, 48'h40, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 48'h80, 1'b0, 32'h0);
        send_item(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0);
        send_item(OP_INSTALL, 48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_INSTALL, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h5);
        send_item(OP_INSTALL, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h5);
        send_item(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h7);
        send_item(OP_INSTALL, 48'h0, 1'b1, 32'h0);
        wait_drained();
        // zero ways, zero index bits, zero seed, random mode
        write_reg(CFG_WAYS, 16'd0);
        write_reg(CFG_SIDX, 16'd0);
        write_reg(CFG_SEED, 16'd0);
        write_reg(CFG_MODE, 16'd1);
        for (int i = 0; i < 4; i++)
            send_item(OP_INSTALL, 48'h1234_0000_0000 + i, 1'b1, 32'(i));
        send_item(OP_LOOKUP, 48'h1234_0000_0003, 1'b0, 32'h9);
        wait_drained();
        write_reg(CFG_WAYS, 16'd31);
        write_reg(CFG_SIDX, 16'd15);
        write_reg(CFG_SEED, 16'hFFFF);
        for (int i = 0; i < 20; i++)
            send_item(OP_INSTALL, {8'($urandom_range(0, 7)), 40'h77}, 1'b1, 32'(i));
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_MODE, CFG_W'(ph[0]));
            write_reg(CFG_SIDX, ph == 5 ? 16'd8 : CFG_W'($urandom_range(0, 8)));
            write_reg(CFG_WAYS, ph == 2 ? 16'd16 : CFG_W'($urandom_range(1, 6)));
            write_reg(CFG_SEED, 16'($urandom_range(0, 65535)));
            if (ph == 1) long_hold = 1'b1;
            if (ph == 5) no_idle = 1'b1;
            for (int i = 0; i < 250; i++) random_item(3);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sactl_pkg.sv
rtl/sactl_ram.sv
rtl/set_assoc_cache_tag_lru_top.sv
dv/set_assoc_cache_tag_lru_chk.sv
dv/set_assoc_cache_tag_lru_top_tb.sv
